### rtl/core/lkv_pkg.sv
// Package for the LRU key-value cache: field widths, request codes, reset values
// and the status bundle passed from the scan unit to the sequencer.
// No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int CAP_W          = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Value returned by a get that misses (all ones, i.e. -1).
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    // Request codes on the req_type field.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // What one scan over the entries has found.
    typedef struct packed {
        logic match_found;   // a valid entry holds the requested key
        logic free_found;    // an invalid entry exists
        logic lru_found;     // a valid entry carries the least recent rank
    } scan_flags_t;

endpackage

### rtl/core/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with least-recently-used
// replacement. Depends on lkv_pkg, lkv_mem and lkv_scan.
`timescale 1ns / 1ps

// Each request is a get or a put on a 32-bit key and produces exactly one result
// transfer. The block works on one request at a time: a scan pass over all ENTRIES
// entries, a decision step, a value read for a get that hits, a recency pass and
// the result step; a get that misses skips the recency pass. If the previous
// result is still waiting for m_ready when the next one is ready, the block holds
// in its result step until that result is taken. The block makes two sequential
// passes over the entry stores. Each pass handles one entry per cycle and then
// drains the read pipeline. The scan pass drives a single key comparator and rank
// comparator. The recency pass then ages the ranks through the single write port
// of the rank memory. Keys, values and ranks live in memories; only the valid
// bits are flip-flops, so a capacity write or reset empties the cache at once,
// with no clearing pass. The capacity register (reset 16) is written through the
// cfg channel while the block is idle; a value of zero acts as one and a value
// above ENTRIES acts as ENTRIES. A finished result sits in an output register, so
// a new request is taken while the previous result still waits to be collected.

module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [lkv_pkg::KEY_W-1:0]         s_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  s_write_value,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  m_read_value,
    // Capacity register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         cfg_capacity
);

    import lkv_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int OCC_W = CNT_W;
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_READ,
        S_UPDATE,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    // Request held for the duration of the work.
    logic              req_put_reg, req_put_next;
    logic [KEY_W-1:0]  req_key_reg, req_key_next;
    logic [VAL_W-1:0]  req_val_reg, req_val_next;

    // Address sequencer and read pipeline tag.
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    // Cache bookkeeping.
    logic [CAP_W-1:0]   capacity_reg, capacity_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    // Recency pass controls.
    logic [IDX_W-1:0]  target_reg, target_next;
    logic              age_all_reg, age_all_next;
    logic [IDX_W-1:0]  age_rank_reg, age_rank_next;

    // Result being built and the output register.
    logic              resp_hit_reg, resp_hit_next;
    logic [VAL_W-1:0]  resp_value_reg, resp_value_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg, m_hit_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;

    // Memory ports.
    logic              key_we, val_we, rank_we;
    logic [IDX_W-1:0]  wr_slot;
    logic [IDX_W-1:0]  rank_waddr;
    logic [IDX_W-1:0]  rank_wdata;
    logic [IDX_W-1:0]  val_raddr;
    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic [IDX_W-1:0]  rank_rdata;

    // Scan unit.
    logic              scan_clr, scan_en;
    scan_flags_t       scan_flags;
    logic [IDX_W-1:0]  match_slot, match_rank, free_slot, lru_slot;

    logic [CMP_W-1:0]  cap_ext, cap_eff, occ_ext;
    logic [OCC_W-1:0]  occ_m1;
    logic [IDX_W-1:0]  lru_rank;
    logic              issue;
    logic              cache_full;

    // Effective capacity: zero behaves as one, anything above ENTRIES saturates.
    always_comb begin
        cap_ext = CMP_W'(capacity_reg);
        if (capacity_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign occ_ext    = CMP_W'(occ_reg);
    assign cache_full = (occ_ext >= cap_eff);
    assign occ_m1     = occ_reg - OCC_W'(1);
    assign lru_rank   = occ_m1[IDX_W-1:0];
    assign issue      = (idx_reg < CNT_W'(ENTRIES));

    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        req_put_next    = req_put_reg;
        req_key_next    = req_key_reg;
        req_val_next    = req_val_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        capacity_next   = capacity_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        target_next     = target_reg;
        age_all_next    = age_all_reg;
        age_rank_next   = age_rank_reg;
        resp_hit_next   = resp_hit_reg;
        resp_value_next = resp_value_reg;
        m_valid_next    = m_valid_reg;
        m_hit_next      = m_hit_reg;
        m_value_next    = m_value_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        rank_we         = 1'b0;
        wr_slot         = target_reg;
        rank_waddr      = rd_idx_reg;
        rank_wdata      = '0;
        val_raddr       = match_slot;
        scan_clr        = 1'b0;
        scan_en         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    // A capacity write empties the cache.
                    capacity_next = cfg_capacity;
                    valid_next    = '0;
                    occ_next      = '0;
                end else if (s_valid) begin
                    req_put_next = s_req_type;
                    req_key_next = s_key;
                    req_val_next = $unsigned(s_write_value);
                    idx_next     = '0;
                    scan_clr     = 1'b1;
                    state_next   = S_SCAN;
                end
            end

            S_SCAN: begin
                scan_en = rd_vld_reg;
                if (issue) begin
                    idx_next    = idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                end else if (!rd_vld_reg) begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                idx_next        = '0;
                resp_hit_next   = scan_flags.match_found;
                resp_value_next = '0;
                if (scan_flags.match_found) begin
                    // Hit: the matching entry becomes most recent.
                    target_next   = match_slot;
                    age_all_next  = 1'b0;
                    age_rank_next = match_rank;
                    if (req_put_reg == REQ_PUT) begin
                        val_we     = 1'b1;
                        wr_slot    = match_slot;
                        state_next = S_UPDATE;
                    end else begin
                        state_next = S_READ;
                    end
                end else if (req_put_reg == REQ_GET) begin
                    resp_value_next = $unsigned(MISS_VALUE);
                    state_next      = S_RESP;
                end else if (cache_full) begin
                    // Insert into a full cache reuses the least recent slot.
                    if (scan_flags.lru_found) begin
                        target_next   = lru_slot;
                        age_all_next  = 1'b0;
                        age_rank_next = lru_rank;
                        key_we        = 1'b1;
                        val_we        = 1'b1;
                        wr_slot       = lru_slot;
                        state_next    = S_UPDATE;
                    end else begin
                        state_next = S_RESP;
                    end
                end else if (scan_flags.free_found) begin
                    // Insert into the lowest free slot; every valid entry ages.
                    target_next           = free_slot;
                    age_all_next          = 1'b1;
                    age_rank_next         = '0;
                    key_we                = 1'b1;
                    val_we                = 1'b1;
                    wr_slot               = free_slot;
                    valid_next[free_slot] = 1'b1;
                    occ_next              = occ_reg + OCC_W'(1);
                    state_next            = S_UPDATE;
                end else begin
                    state_next = S_RESP;
                end
            end

            S_READ: begin
                resp_value_next = val_rdata;
                state_next      = S_UPDATE;
            end

            S_UPDATE: begin
                if (rd_vld_reg) begin
                    if (rd_idx_reg == target_reg) begin
                        rank_we    = 1'b1;
                        rank_wdata = '0;
                    end else if (valid_reg[rd_idx_reg] &&
                                 (age_all_reg || (rank_rdata < age_rank_reg))) begin
                        rank_we    = 1'b1;
                        rank_wdata = rank_rdata + IDX_W'(1);
                    end
                end
                if (issue) begin
                    idx_next    = idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                end else if (!rd_vld_reg) begin
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = resp_hit_reg;
                    m_value_next = resp_value_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_vld_reg   <= 1'b0;
            idx_reg      <= '0;
            capacity_reg <= CAPACITY_RESET;
            valid_reg    <= '0;
            occ_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            idx_reg      <= idx_next;
            capacity_reg <= capacity_next;
            valid_reg    <= valid_next;
            occ_reg      <= occ_next;
            m_valid_reg  <= m_valid_next;
        end
        req_put_reg    <= req_put_next;
        req_key_reg    <= req_key_next;
        req_val_reg    <= req_val_next;
        rd_idx_reg     <= rd_idx_next;
        target_reg     <= target_next;
        age_all_reg    <= age_all_next;
        age_rank_reg   <= age_rank_next;
        resp_hit_reg   <= resp_hit_next;
        resp_value_reg <= resp_value_next;
        m_hit_reg      <= m_hit_next;
        m_value_reg    <= m_value_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = $signed(m_value_reg);

    lkv_mem #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_key_mem (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_slot),
        .wdata (req_key_reg),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    lkv_mem #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_val_mem (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (wr_slot),
        .wdata (req_val_reg),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    lkv_mem #(
        .WIDTH (IDX_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_rank_mem (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rank_rdata)
    );

    lkv_scan #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr        (scan_clr),
        .en         (scan_en),
        .slot       (rd_idx_reg),
        .ent_valid  (valid_reg[rd_idx_reg]),
        .ent_key    (key_rdata),
        .ent_rank   (rank_rdata),
        .req_key    (req_key_reg),
        .lru_rank   (lru_rank),
        .flags      (scan_flags),
        .match_slot (match_slot),
        .match_rank (match_rank),
        .free_slot  (free_slot),
        .lru_slot   (lru_slot)
    );

endmodule

### rtl/core/lkv_mem.sv
// Simple dual-port memory with one write port and one registered read port.
// Used for the key, value and recency stores; depends on nothing.
`timescale 1ns / 1ps

module lkv_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lkv_scan.sv
// Shared compare unit: takes one entry per cycle and keeps the first key match,
// the first free slot and the least recent slot. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_scan #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clr,
    input  logic                       en,
    input  logic [IDX_W-1:0]           slot,
    input  logic                       ent_valid,
    input  logic [lkv_pkg::KEY_W-1:0]  ent_key,
    input  logic [IDX_W-1:0]           ent_rank,
    input  logic [lkv_pkg::KEY_W-1:0]  req_key,
    input  logic [IDX_W-1:0]           lru_rank,
    output lkv_pkg::scan_flags_t       flags,
    output logic [IDX_W-1:0]           match_slot,
    output logic [IDX_W-1:0]           match_rank,
    output logic [IDX_W-1:0]           free_slot,
    output logic [IDX_W-1:0]           lru_slot
);

    import lkv_pkg::*;

    scan_flags_t      flags_reg, flags_next;
    logic [IDX_W-1:0] match_slot_reg, match_slot_next;
    logic [IDX_W-1:0] match_rank_reg, match_rank_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic [IDX_W-1:0] lru_slot_reg, lru_slot_next;

    always_comb begin
        flags_next      = flags_reg;
        match_slot_next = match_slot_reg;
        match_rank_next = match_rank_reg;
        free_slot_next  = free_slot_reg;
        lru_slot_next   = lru_slot_reg;
        if (clr) begin
            flags_next = '0;
        end else if (en) begin
            // Only the first hit of each kind counts, as in a lowest-index search.
            if (ent_valid && (ent_key == req_key) && !flags_reg.match_found) begin
                flags_next.match_found = 1'b1;
                match_slot_next        = slot;
                match_rank_next        = ent_rank;
            end
            if (!ent_valid && !flags_reg.free_found) begin
                flags_next.free_found = 1'b1;
                free_slot_next        = slot;
            end
            if (ent_valid && (ent_rank == lru_rank) && !flags_reg.lru_found) begin
                flags_next.lru_found = 1'b1;
                lru_slot_next        = slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
        match_slot_reg <= match_slot_next;
        match_rank_reg <= match_rank_next;
        free_slot_reg  <= free_slot_next;
        lru_slot_reg   <= lru_slot_next;
    end

    assign flags      = flags_reg;
    assign match_slot = match_slot_reg;
    assign match_rank = match_rank_reg;
    assign free_slot  = free_slot_reg;
    assign lru_slot   = lru_slot_reg;

endmodule

### rtl/core/lkv_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lkv_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_hit,
    input  logic signed [lkv_pkg::VAL_W-1:0]  m_read_value,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready
);

    import lkv_pkg::*;

    // One request at a time: once a transfer is taken the block is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a previous one is still in progress");

    // A capacity write and a request are never taken in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |-> !(s_valid && s_ready))
        else $error("capacity write coincides with a request transfer");

    // A miss returns either the miss marker (get) or zero (put).
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> ((m_read_value == MISS_VALUE) || (m_read_value == '0)))
        else $error("miss result carries an unexpected value");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hit) && $stable(m_read_value)))
        else $error("stalled result changed or was withdrawn");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

### test/tb_lru_key_value_cache.sv
// Self-checking testbench for lru_key_value_cache: a directed table, then random
// get/put traffic under several capacity settings, checked against a local LRU model.
// Depends on lkv_pkg and the RTL of lru_key_value_cache only.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

    import lkv_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 9;
    localparam int ENTRIES     = ENTRIES_DEFAULT;

    // Random traffic is split into phases, one per capacity setting.
    localparam int PHASE_ITEMS = 165;
    localparam int PHASES      = 11;

    // The result side holds off once, long enough for the block to fill up and
    // drop s_ready while requests keep being offered.
    localparam int HOLD_AT_RESULT = 700;
    localparam int HOLD_CYCLES    = 400;

    // Quiet time after the last result.
    localparam int TAIL_CYCLES = 4 * ENTRIES + 16;

    // Time limit for the whole run, with ample margin over the slowest legal run.
    localparam int WATCHDOG_NS = 500_000 * CLK_PERIOD;

    localparam logic signed [VAL_W-1:0] PUT_VALUE = '0;

    // Outcome of one request as the cache should report it.
    typedef struct {
        logic                    hit;
        logic signed [VAL_W-1:0] value;
    } lookup_t;

    // One row of the directed table: either a request or a capacity write.
    // Where literal is set, the outcome is typed into the row rather than
    // taken from the local model.
    typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              req;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  wval;
        logic [CAP_W-1:0]  cap;
        logic              literal;
        logic              hit;
        logic [VAL_W-1:0]  value;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Empty cache after reset: both extreme keys miss.
        '{ROW_REQ, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_REQ, REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, MISS_VALUE},
        // Inserts carrying the extreme values.
        '{ROW_REQ, REQ_PUT, 32'h0000_0000, 32'h7FFF_FFFF, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_REQ, REQ_GET, 32'hFFFF_FFFF, 32'h5555_AAAA, 5'd0, 1'b1, 1'b1, 32'h8000_0000},
        // Overwrite of a present key, then read it back.
        '{ROW_REQ, REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b1, PUT_VALUE},
        '{ROW_REQ, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h1234_5678, 32'hAAAA_5555, 5'd0, 1'b1, 1'b0, MISS_VALUE},
        // Capacity zero behaves as one, and the write empties the cache.
        '{ROW_CAP, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_REQ, REQ_PUT, 32'h0000_0001, 32'h0000_0005, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_PUT, 32'h0000_0002, 32'h0000_0006, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_GET, 32'h0000_0001, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h0000_0002, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        // Two lines: a get refreshes A, so the insert of C pushes out B.
        '{ROW_CAP, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_PUT, 32'h0000_000A, 32'h0000_0010, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_PUT, 32'h0000_000B, 32'h0000_0020, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_GET, 32'h0000_000A, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_PUT, 32'h0000_000C, 32'h0000_0030, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h0000_000B, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h0000_000A, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h0000_000C, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0},
        // Capacity above the entry count saturates; the write clears again.
        '{ROW_CAP, REQ_GET, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_GET, 32'h0000_000A, 32'h0000_0000, 5'd0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_REQ, REQ_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd0, 1'b1, 1'b0, PUT_VALUE},
        '{ROW_REQ, REQ_GET, 32'hA5A5_A5A5, 32'h0000_0000, 5'd0, 1'b0, 1'b0, '0}
    };

    // Capacity settings for the random phases; the last one is drawn at random.
    localparam logic [CAP_W-1:0] CAP_PLAN [PHASES-1] = '{
        5'd16, 5'd1, 5'd0, 5'd17, 5'd2, 5'd5, 5'd8, 5'd12, 5'd15, 5'd31
    };

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_req_type;
    logic [KEY_W-1:0]        s_key;
    logic signed [VAL_W-1:0] s_write_value;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_hit;
    logic signed [VAL_W-1:0] m_read_value;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        cfg_capacity;

    // Local copy of the cache contents and of the capacity register.
    logic             line_valid [ENTRIES];
    logic [KEY_W-1:0] line_key   [ENTRIES];
    logic [VAL_W-1:0] line_value [ENTRIES];
    int unsigned      line_rank  [ENTRIES];
    int unsigned      fill_count;
    logic [CAP_W-1:0] capacity_reg;

    // Outcomes of accepted requests whose result transfer has not yet arrived.
    lookup_t lookup_queue [$];

    // Both sides insert random gaps only while this is set.
    bit gaps_on;

    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned lookup_errors;
    int unsigned settings_used;
    int unsigned get_hits, get_misses, put_updates, put_inserts, evictions;

    lru_key_value_cache #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_capacity  (cfg_capacity)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // LRU model. Ranks count up from 0 (most recent) to fill_count-1
    // (least recent) across the valid lines.
    // ------------------------------------------------------------------

    function automatic void flush_lines();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i]   = '0;
            line_value[i] = '0;
            line_rank[i]  = 0;
        end
        fill_count = 0;
    endfunction

    // A capacity of zero still allows one line, and nothing beyond the
    // physical entries can be used.
    function automatic int unsigned usable_lines();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > ENTRIES)
            return ENTRIES;
        return int'(capacity_reg);
    endfunction

    // Make a line the most recent; only the lines that were more recent age.
    function automatic void promote(input int slot);
        int          i;
        int unsigned old_rank;
        old_rank = line_rank[slot];
        for (i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_rank[i] < old_rank)
                line_rank[i]++;
        line_rank[slot] = 0;
    endfunction

    function automatic void insert_line(input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] value);
        int i;
        int slot;
        slot = -1;
        if (fill_count >= usable_lines()) begin
            // Full: the least recent line is taken over by the new key.
            for (i = 0; i < ENTRIES; i++)
                if (line_valid[i] && line_rank[i] == fill_count - 1) begin
                    slot = i;
                    break;
                end
            if (slot < 0)
                return;
            line_key[slot]   = key;
            line_value[slot] = value;
            promote(slot);
            evictions++;
            return;
        end
        // Otherwise the lowest-numbered free line is filled and all others age.
        for (i = 0; i < ENTRIES; i++)
            if (!line_valid[i]) begin
                slot = i;
                break;
            end
        if (slot < 0)
            return;
        for (i = 0; i < ENTRIES; i++)
            if (line_valid[i])
                line_rank[i]++;
        line_valid[slot] = 1'b1;
        line_key[slot]   = key;
        line_value[slot] = value;
        line_rank[slot]  = 0;
        fill_count++;
    endfunction

    // Applies one request to the local cache and returns what the block must report.
    function automatic lookup_t lru_access(input logic req,
                                           input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] value);
        lookup_t outcome;
        int      i;
        int      slot;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_key[i] == key) begin
                slot = i;
                break;
            end
        outcome.hit   = (slot >= 0);
        outcome.value = PUT_VALUE;
        if (req == REQ_PUT) begin
            if (slot >= 0) begin
                line_value[slot] = value;
                promote(slot);
                put_updates++;
            end else begin
                insert_line(key, value);
                put_inserts++;
            end
        end else begin
            if (slot >= 0) begin
                promote(slot);
                outcome.value = line_value[slot];
                get_hits++;
            end else begin
                outcome.value = MISS_VALUE;
                get_misses++;
            end
        end
        return outcome;
    endfunction

    // ------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------

    // Offers one request and holds it until the transfer completes; at that
    // edge the model is stepped and the outcome queued. s_valid is left high,
    // so a following request with no gap keeps it high without a dip.
    task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] wval, input logic literal,
                                input logic lit_hit, input logic [VAL_W-1:0] lit_value);
        int unsigned gap;
        lookup_t     outcome;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_key         <= key;
        s_write_value <= wval;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        outcome = lru_access(req, key, wval);
        if (literal) begin
            outcome.hit   = lit_hit;
            outcome.value = lit_value;
        end
        lookup_queue.push_back(outcome);
        requests_sent++;
    endtask

    // Drops the request valid and waits until every queued outcome has been matched.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (lookup_queue.size() != 0) @(posedge aclk);
    endtask

    // The capacity register is only written with the block drained; the write
    // also empties the model, as it empties the cache.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_until_idle();
        cfg_valid    <= 1'b1;
        cfg_capacity <= cap;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
        capacity_reg = cap;
        flush_lines();
        settings_used++;
    endtask

    // Most keys come from a small pool a little larger than the usable lines,
    // so that hits, updates and evictions are all frequent; a few are fresh
    // random keys that almost always miss.
    task automatic run_random_phase(input int unsigned n_items);
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        int unsigned      pool_size;
        int unsigned      k;
        pool_size = usable_lines() + $urandom_range(1, 6);
        repeat (pool_size) key_pool.push_back($urandom);
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 8)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request(1'($urandom_range(0, 1)), key, $urandom, 1'b0, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int r;
        int p;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= REQ_GET;
        s_key         <= '0;
        s_write_value <= '0;
        cfg_valid     <= 1'b0;
        cfg_capacity  <= '0;
        gaps_on       = 1'b1;
        capacity_reg  = CAPACITY_RESET;
        flush_lines();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table first, at the reset capacity until its first write.
        for (r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CAP)
                write_capacity(DIRECTED[r].cap);
            else
                send_request(DIRECTED[r].req, DIRECTED[r].key, DIRECTED[r].wval,
                             DIRECTED[r].literal, DIRECTED[r].hit, DIRECTED[r].value);
        end

        // Random phases. Every third one runs both sides back to back.
        for (p = 0; p < PHASES; p++) begin
            if (p < PHASES - 1)
                write_capacity(CAP_PLAN[p]);
            else
                write_capacity(CAP_W'($urandom_range(0, 31)));
            gaps_on = (p % 3) != 2;
            run_random_phase(PHASE_ITEMS);
        end

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d result transfers for %0d requests over %0d capacity settings.",
                 results_seen, requests_sent, settings_used);
        $display("Gets: %0d hits, %0d misses. Puts: %0d updates, %0d inserts, %0d evictions.",
                 get_hits, get_misses, put_updates, put_inserts, evictions);
        if (lookup_errors == 0 && lookup_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls on m_ready, one long hold, and the check
    // of each transfer against the oldest queued outcome.
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string what, input logic [VAL_W-1:0] want,
                                          input logic [VAL_W-1:0] got);
        lookup_errors++;
        if (lookup_errors <= 10)
            $display("%0t ns: result %0d, %s: expected %h, got %h",
                     $time, results_seen, what, want, got);
    endfunction

    initial begin : result_sink
        int unsigned stall;
        lookup_t     want;
        bit          held;

        m_ready <= 1'b0;
        held    = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);

        forever begin
            if (!held && results_seen == HOLD_AT_RESULT) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else begin
                stall = gaps_on ? $urandom_range(0, 4) : 0;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            results_seen++;
            if (lookup_queue.size() == 0) begin
                note_mismatch("transfer with no request outstanding", 'x, m_read_value);
            end else begin
                want = lookup_queue.pop_front();
                if (m_hit !== want.hit)
                    note_mismatch("hit", VAL_W'(want.hit), VAL_W'(m_hit));
                if (m_read_value !== want.value)
                    note_mismatch("read_value", want.value, m_read_value);
            end
        end
    end

    // Hard stop in case the block hangs on either channel.
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Timeout after %0d ns with %0d results still outstanding.",
                 WATCHDOG_NS, lookup_queue.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
